// File: hdl/olar_pkg.sv
package olar_pkg;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  localparam int unsigned ValueW = 32;

endpackage

// File: hdl/olar_ram.sv
module olar_ram import olar_pkg::*; #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [ValueW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [ValueW-1:0] rdata_o
);

  logic [ValueW-1:0] mem_q [Depth];
  logic [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ordered_list_append_remove_core.sv
// Ordered list of up to DEPTH signed 32-bit values kept in arrival order in a
// single-port-read, single-port-write RAM with a registered read. Append
// writes the RAM on the input transfer, unless the list is full, and places
// its result in the output register from the done state. Remove scans from
// the head at one entry per cycle and then moves each later entry, if any, up
// by one, again one per cycle. List reads and then presents each entry in
// turn, since the one read port has registered data. A new item is taken as
// soon as the previous one has placed its last result in the output register;
// a stalled output stalls the list walk and the final result of any action.
module ordered_list_append_remove_core import olar_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               action_i,
  input  logic signed [ValueW-1:0] item_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [ValueW-1:0] out_value_o,
  output logic                     last_item_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SEARCH  = 6'b000010,
    S_SHIFT   = 6'b000100,
    S_LIST_RD = 6'b001000,
    S_LIST_WR = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   iss_q, iss_d;
  logic              rvld_q, rvld_d;
  logic [IdxW-1:0]   ridx_q, ridx_d;
  status_e           status_q, status_d;
  logic [ValueW-1:0] val_q;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [ValueW-1:0] out_value_q;
  logic              out_last_q;

  logic              push;
  status_e           push_status;
  logic [ValueW-1:0] push_value;
  logic              push_last;

  logic              we, re;
  logic [IdxW-1:0]   waddr, raddr;
  logic [ValueW-1:0] wdata, rdata;

  logic              in_xfer, out_free, match, ridx_last;
  logic [CntW-1:0]   last_idx, ridx_ext;

  olar_ram #(
    .Depth (DEPTH),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_idx   = count_q - 1'b1;
  assign ridx_ext   = CntW'(ridx_q);
  assign ridx_last  = (ridx_ext == last_idx);
  assign match      = (rdata == val_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    iss_d       = iss_q;
    rvld_d      = 1'b0;
    ridx_d      = ridx_q;
    status_d    = status_q;
    push        = 1'b0;
    push_status = ST_OK;
    push_value  = '0;
    push_last   = 1'b1;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          iss_d = '0;
          case (action_i)
            ACT_APPEND: begin
              if (count_q == DepthC) begin
                status_d = ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = count_q[IdxW-1:0];
                wdata    = item_value_i;
                count_d  = count_q + 1'b1;
                status_d = ST_OK;
              end
              state_d = S_DONE;
            end
            ACT_REMOVE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                state_d = S_SEARCH;
              end
            end
            ACT_LIST: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                state_d = S_LIST_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (rvld_q && match) begin
          if (ridx_last) begin
            count_d  = count_q - 1'b1;
            status_d = ST_OK;
            state_d  = S_DONE;
          end else begin
            iss_d   = ridx_ext + 1'b1;
            state_d = S_SHIFT;
          end
        end else if (rvld_q && ridx_last) begin
          status_d = ST_NOTFOUND;
          state_d  = S_DONE;
        end else if (iss_q < count_q) begin
          re     = 1'b1;
          raddr  = iss_q[IdxW-1:0];
          rvld_d = 1'b1;
          ridx_d = iss_q[IdxW-1:0];
          iss_d  = iss_q + 1'b1;
        end
      end
      S_SHIFT: begin
        // move each later entry up by one
        if (rvld_q) begin
          we    = 1'b1;
          waddr = ridx_q - 1'b1;
          wdata = rdata;
        end
        if (rvld_q && ridx_last) begin
          count_d  = count_q - 1'b1;
          status_d = ST_OK;
          state_d  = S_DONE;
        end else if (iss_q < count_q) begin
          re     = 1'b1;
          raddr  = iss_q[IdxW-1:0];
          rvld_d = 1'b1;
          ridx_d = iss_q[IdxW-1:0];
          iss_d  = iss_q + 1'b1;
        end
      end
      S_LIST_RD: begin
        re      = 1'b1;
        raddr   = iss_q[IdxW-1:0];
        state_d = S_LIST_WR;
      end
      S_LIST_WR: begin
        if (out_free) begin
          push        = 1'b1;
          push_status = ST_OK;
          push_value  = rdata;
          push_last   = (iss_q == last_idx);
          if (iss_q == last_idx) begin
            state_d = S_IDLE;
          end else begin
            iss_d   = iss_q + 1'b1;
            state_d = S_LIST_RD;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          push        = 1'b1;
          push_status = status_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      iss_q       <= '0;
      rvld_q      <= 1'b0;
      ridx_q      <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      iss_q    <= iss_d;
      rvld_q   <= rvld_d;
      ridx_q   <= ridx_d;
      status_q <= status_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      val_q <= item_value_i;
    end
    if (push) begin
      out_status_q <= push_status;
      out_value_q  <= push_value;
      out_last_q   <= push_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_value_o = out_value_q;
  assign last_item_o = out_last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above depth");

  a_full_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && action_i == ACT_APPEND && count_q == DepthC) |=> $stable(count_q))
    else $error("append on full list changed count");

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && state_q == S_SHIFT) |-> (CntW'(waddr) + 1'b1 < count_q))
    else $error("shift write outside stored entries");

  a_notlast_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_item_o) |-> (status_o == ST_OK))
    else $error("non-final result with error status");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(out_value_q) && out_valid_q))
    else $error("stalled result overwritten");

endmodule
